@@ hdl/pid_with_antiwindup_defines.svh @@
// Assertion macros shared by the PID controller RTL.
`ifndef PID_WITH_ANTIWINDUP_DEFINES_SVH
`define PID_WITH_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hdl/pwa_pkg.sv @@
// Types, constants and helper functions of the PID controller.
`timescale 1ns / 1ps
`default_nettype none
package pwa_pkg;

    localparam int ACC_W   = 56;
    localparam int SUM_W   = 44;
    localparam int OPA_W   = 34;
    localparam int OPB_W   = 20;
    localparam int DIGIT_W = 4;

    localparam logic [2:0] DIG_LAST = 3'd4;

    localparam logic [2:0] REG_PROP    = 3'd0;
    localparam logic [2:0] REG_INTEG   = 3'd1;
    localparam logic [2:0] REG_DERIV   = 3'd2;
    localparam logic [2:0] REG_BACK    = 3'd3;
    localparam logic [2:0] REG_FF      = 3'd4;
    localparam logic [2:0] REG_SMOOTH  = 3'd5;
    localparam logic [2:0] REG_LIMITS  = 3'd6;
    localparam logic [2:0] REG_TIMING  = 3'd7;

    localparam logic [16:0] SMOOTH_RESET = 17'd65536;
    localparam logic [33:0] TIMING_RESET = 34'd6554255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_CLAMP,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_INTEG,
        OP_RAWD,
        OP_SMA,
        OP_SMB,
        OP_PROP,
        OP_INT,
        OP_DER,
        OP_FF,
        OP_BACK
    } op_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -48'sh0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // The maximum is applied first, so the minimum wins when they cross.
    function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        r = x;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pid_with_antiwindup.sv @@
// PID controller with back-calculation anti-windup, top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_with_antiwindup_defines.svh"

// One sample runs through nine signed products on a single shared multiplier.
// The multiplier takes the narrow operand four bits per cycle, so each product
// is built from five digits between a load state and a post state. A compute
// beat adds a clamp state after the feedforward product and a finish state
// after the back-calculation product before the done state; a clear beat goes
// from idle straight to the done state. The input side is ready only while the
// sequencer is idle. The result sits in an output register, so the next beat
// can be accepted while it waits to be taken.
module pid_with_antiwindup (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // target[15:0], measured[31:16], disturb[47:32]
    input  wire logic        s_tuser,   // action: 0 compute, 1 clear
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // effort[15:0], integral_now[47:16], derivative_now[79:48]
);

    localparam int SUM_W_L = pwa_pkg::SUM_W;
    localparam int ACC_W_L = pwa_pkg::ACC_W;

    pwa_pkg::state_t state_reg, state_next;
    pwa_pkg::op_t    op_reg;

    logic signed [15:0] prop_reg, igain_reg, dgain_reg, kb_reg, ff_reg;
    logic [16:0]        smooth_reg;
    logic [63:0]        limits_reg;
    logic [33:0]        timing_reg;

    logic signed [31:0] integ_reg, deriv_reg, rawd_reg, raw_reg, clamped_reg;
    logic signed [16:0] err_reg, last_err_reg;
    logic signed [15:0] dist_reg;
    logic signed [SUM_W_L-1:0] sum_reg;
    logic               clr_reg;

    logic signed [ACC_W_L-1:0] acc_reg, a_reg;
    logic signed [pwa_pkg::OPB_W-1:0] b_reg;
    logic [2:0] dig_cnt_reg;

    logic signed [pwa_pkg::OPA_W-1:0] a_sel;
    logic signed [pwa_pkg::OPB_W-1:0] b_sel;
    logic signed [4:0]          digit;
    logic signed [ACC_W_L-1:0]  step_prod;
    logic [16:0]                s_eff;
    logic [16:0]                s_comp;
    logic signed [17:0]         err_diff;
    logic signed [31:0]         out_lo, out_hi, int_lo, int_hi;
    logic signed [31:0]         raw_sat;
    logic signed [31:0]         eff_src;
    logic                       in_fire, out_load, m_valid_reg;
    logic [79:0]                m_data_reg;

    localparam logic signed [ACC_W_L-1:0] RAWD_HI = 32767;
    localparam logic signed [ACC_W_L-1:0] RAWD_LO = -32768;

    assign in_fire  = s_tvalid && s_tready;
    assign s_eff    = (smooth_reg > pwa_pkg::SMOOTH_RESET) ? pwa_pkg::SMOOTH_RESET
                                                           : smooth_reg;
    assign s_comp   = 17'(pwa_pkg::SMOOTH_RESET - s_eff);
    assign err_diff = 18'(err_reg) - 18'(last_err_reg);
    assign out_lo   = {limits_reg[15:0], 16'b0};
    assign out_hi   = {limits_reg[31:16], 16'b0};
    assign int_lo   = {limits_reg[47:32], 16'b0};
    assign int_hi   = {limits_reg[63:48], 16'b0};
    assign raw_sat  = pwa_pkg::sat32(48'(sum_reg));
    assign eff_src  = timing_reg[32] ? clamped_reg : raw_reg;

    // The top digit of the narrow operand carries its sign.
    assign digit     = (dig_cnt_reg == pwa_pkg::DIG_LAST) ? {b_reg[3], b_reg[3:0]}
                                                          : {1'b0, b_reg[3:0]};
    assign step_prod = a_reg * digit;

    always_comb
    begin
        a_sel = '0;
        b_sel = '0;
        case (op_reg)
            pwa_pkg::OP_INTEG:
            begin
                a_sel = {18'b0, timing_reg[15:0]};
                b_sel = 20'(err_reg);
            end
            pwa_pkg::OP_RAWD:
            begin
                a_sel = {18'b0, timing_reg[31:16]};
                b_sel = 20'(err_diff);
            end
            pwa_pkg::OP_SMA:
            begin
                a_sel = 34'(rawd_reg);
                b_sel = {3'b0, s_eff};
            end
            pwa_pkg::OP_SMB:
            begin
                a_sel = 34'(deriv_reg);
                b_sel = {3'b0, s_comp};
            end
            pwa_pkg::OP_PROP:
            begin
                a_sel = 34'(prop_reg);
                b_sel = 20'(err_reg);
            end
            pwa_pkg::OP_INT:
            begin
                a_sel = 34'(integ_reg);
                b_sel = 20'(igain_reg);
            end
            pwa_pkg::OP_DER:
            begin
                a_sel = 34'(deriv_reg);
                b_sel = 20'(dgain_reg);
            end
            pwa_pkg::OP_FF:
            begin
                a_sel = 34'(ff_reg);
                b_sel = 20'(dist_reg);
            end
            pwa_pkg::OP_BACK:
            begin
                a_sel = 34'(clamped_reg) - 34'(raw_reg);
                b_sel = 20'(kb_reg);
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwa_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = s_tuser ? pwa_pkg::ST_DONE : pwa_pkg::ST_LOAD;
            pwa_pkg::ST_LOAD:
                state_next = pwa_pkg::ST_MUL;
            pwa_pkg::ST_MUL:
                if (dig_cnt_reg == pwa_pkg::DIG_LAST)
                    state_next = pwa_pkg::ST_POST;
            pwa_pkg::ST_POST:
                if (op_reg == pwa_pkg::OP_FF)
                    state_next = pwa_pkg::ST_CLAMP;
                else if (op_reg == pwa_pkg::OP_BACK)
                    state_next = pwa_pkg::ST_FINISH;
                else
                    state_next = pwa_pkg::ST_LOAD;
            pwa_pkg::ST_CLAMP:
                state_next = pwa_pkg::ST_LOAD;
            pwa_pkg::ST_FINISH:
                state_next = pwa_pkg::ST_DONE;
            pwa_pkg::ST_DONE:
                if (!m_valid_reg || m_tready)
                    state_next = pwa_pkg::ST_IDLE;
            default:
                state_next = pwa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            pwa_pkg::ST_IDLE:
                s_tready = 1'b1;
            pwa_pkg::ST_DONE:
                out_load = !m_valid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_reg   <= '0;
            igain_reg  <= '0;
            dgain_reg  <= '0;
            kb_reg     <= '0;
            ff_reg     <= '0;
            smooth_reg <= pwa_pkg::SMOOTH_RESET;
            limits_reg <= '0;
            timing_reg <= pwa_pkg::TIMING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pwa_pkg::REG_PROP:   prop_reg   <= cfg_data[15:0];
                pwa_pkg::REG_INTEG:  igain_reg  <= cfg_data[15:0];
                pwa_pkg::REG_DERIV:  dgain_reg  <= cfg_data[15:0];
                pwa_pkg::REG_BACK:   kb_reg     <= cfg_data[15:0];
                pwa_pkg::REG_FF:     ff_reg     <= cfg_data[15:0];
                pwa_pkg::REG_SMOOTH: smooth_reg <= cfg_data[16:0];
                pwa_pkg::REG_LIMITS: limits_reg <= cfg_data;
                pwa_pkg::REG_TIMING: timing_reg <= cfg_data[33:0];
                default:             limits_reg <= limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= pwa_pkg::OP_INTEG;
            integ_reg    <= '0;
            deriv_reg    <= '0;
            last_err_reg <= '0;
            rawd_reg     <= '0;
            raw_reg      <= '0;
            clamped_reg  <= '0;
            err_reg      <= '0;
            dist_reg     <= '0;
            sum_reg      <= '0;
            clr_reg      <= 1'b0;
            acc_reg      <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            dig_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                pwa_pkg::ST_IDLE:
                    if (in_fire)
                    begin
                        clr_reg <= s_tuser;
                        op_reg  <= pwa_pkg::OP_INTEG;
                        err_reg <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[31:16]));
                        dist_reg <= s_tdata[47:32];
                        if (s_tuser)
                        begin
                            integ_reg    <= '0;
                            deriv_reg    <= '0;
                            last_err_reg <= '0;
                        end
                    end
                pwa_pkg::ST_LOAD:
                begin
                    a_reg       <= ACC_W_L'(a_sel);
                    b_reg       <= b_sel;
                    dig_cnt_reg <= '0;
                    // The two smoothing products share one accumulation.
                    if (op_reg != pwa_pkg::OP_SMB)
                        acc_reg <= '0;
                end
                pwa_pkg::ST_MUL:
                begin
                    acc_reg     <= acc_reg + step_prod;
                    a_reg       <= a_reg <<< pwa_pkg::DIGIT_W;
                    b_reg       <= b_reg >>> pwa_pkg::DIGIT_W;
                    dig_cnt_reg <= (dig_cnt_reg == pwa_pkg::DIG_LAST) ? 3'd0
                                                                      : dig_cnt_reg + 3'd1;
                end
                pwa_pkg::ST_POST:
                begin
                    op_reg <= pwa_pkg::op_t'(op_reg + 4'd1);
                    case (op_reg)
                        pwa_pkg::OP_INTEG:
                            integ_reg <= pwa_pkg::sat32(48'(integ_reg) + acc_reg[47:0]);
                        pwa_pkg::OP_RAWD:
                            if (acc_reg > RAWD_HI)
                                rawd_reg <= 32'sh7FFF_FFFF;
                            else if (acc_reg < RAWD_LO)
                                rawd_reg <= 32'sh8000_0000;
                            else
                                rawd_reg <= {acc_reg[15:0], 16'b0};
                        pwa_pkg::OP_SMB:
                            deriv_reg <= acc_reg[47:16];
                        pwa_pkg::OP_PROP:
                            sum_reg <= {acc_reg[35:0], 8'b0};
                        pwa_pkg::OP_INT, pwa_pkg::OP_DER:
                            sum_reg <= sum_reg + acc_reg[51:8];
                        pwa_pkg::OP_FF:
                            sum_reg <= sum_reg + {acc_reg[35:0], 8'b0};
                        pwa_pkg::OP_BACK:
                            integ_reg <= pwa_pkg::sat32(48'(integ_reg) + acc_reg[55:8]);
                        default:
                            sum_reg <= sum_reg;
                    endcase
                end
                pwa_pkg::ST_CLAMP:
                begin
                    raw_reg     <= raw_sat;
                    clamped_reg <= pwa_pkg::clamp32(raw_sat, out_lo, out_hi);
                end
                pwa_pkg::ST_FINISH:
                begin
                    if (timing_reg[33])
                        integ_reg <= pwa_pkg::clamp32(integ_reg, int_lo, int_hi);
                    last_err_reg <= err_reg;
                end
                pwa_pkg::ST_DONE:
                    if (out_load)
                    begin
                        m_data_reg  <= {deriv_reg, integ_reg,
                                        clr_reg ? 16'b0 : eff_src[31:16]};
                    end
                default:
                    clr_reg <= clr_reg;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PWA_ASSERT_NOW(a_digit_idle, clk, rst_n, state_reg != pwa_pkg::ST_MUL, dig_cnt_reg == 3'd0, "digit counter runs outside multiply")
    `PWA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, !s_tready, "accepted beat did not start the sequencer")
    `PWA_ASSERT_NEXT(a_clear_state, clk, rst_n, in_fire && s_tuser, integ_reg == 32'sd0 && deriv_reg == 32'sd0 && last_err_reg == 17'sd0, "clear beat left controller state")

endmodule
`default_nettype wire
